// ===== rtl/i2cmrt_pkg.sv =====
// Shared types, codes and buffer sizing for the I2C register transfer sequencer.
package i2cmrt_pkg;

  localparam int BufferDepth = 256;
  localparam int BufAddrW    = (BufferDepth > 1) ? $clog2(BufferDepth) : 1;
  localparam int BufIdxW     = (BufAddrW > 8) ? BufAddrW : 8;

  typedef enum logic [2:0] {
    CmdWrite   = 3'd0,
    CmdRead    = 3'd1,
    CmdEvent   = 3'd2,
    CmdTimeout = 3'd3,
    CmdPush    = 3'd4
  } cmd_e;

  typedef enum logic [3:0] {
    BsStart     = 4'd0,
    BsRepStart  = 4'd1,
    BsSlawAck   = 4'd2,
    BsSlawNack  = 4'd3,
    BsDatawAck  = 4'd4,
    BsDatawNack = 4'd5,
    BsSlarAck   = 4'd6,
    BsSlarNack  = 4'd7,
    BsDatarAck  = 4'd8,
    BsDatarNack = 4'd9,
    BsOther     = 4'd10
  } bus_st_e;

  typedef enum logic [1:0] {
    AckKeep  = 2'd0,
    AckSet   = 2'd1,
    AckClear = 2'd2
  } ack_e;

  typedef enum logic [2:0] {
    StOk      = 3'd0,
    StNak     = 3'd1,
    StInvalid = 3'd2,
    StTimeout = 3'd3,
    StBusy    = 3'd4
  } res_st_e;

  typedef enum logic [2:0] {
    CfgSlaveAddr  = 3'd0,
    CfgRegAddr    = 3'd1,
    CfgSendReg    = 3'd2,
    CfgLenPrefix  = 3'd3,
    CfgXferSize   = 3'd4
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ModeIdle = 3'b001,
    ModeTx   = 3'b010,
    ModeRx   = 3'b100
  } mode_e;

  typedef enum logic [2:0] {
    PhAddr = 3'b001,
    PhLen  = 3'b010,
    PhData = 3'b100
  } phase_e;

  // first member lands in the highest bits
  typedef struct packed {
    logic       was_write;
    logic [7:0] byte_count;
    res_st_e    status;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       rx_valid;
    logic       clear_start;
    ack_e       ack_control;
    logic       request_stop;
    logic       request_start;
    logic [7:0] byte_out;
    logic       drive_byte;
  } result_t;

  function automatic logic buf_hit(logic [7:0] idx);
    return {24'd0, idx} < 32'(BufferDepth);
  endfunction

  function automatic logic [BufAddrW-1:0] buf_addr(logic [7:0] idx);
    logic [BufIdxW-1:0] wide;
    wide = BufIdxW'(idx);
    return wide[BufAddrW-1:0];
  endfunction

endpackage

// ===== rtl/i2cmrt_ram.sv =====
// Generic single-port-write, registered-read RAM.
module i2cmrt_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                       rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/i2c_master_register_transfer_fsm.sv =====
// Top level of the I2C master register transfer sequencer.
//
// Input stream: one beat per command. tuser carries the command (start write,
// start read, bus event, timeout, push byte); tdata carries the bus status,
// the received byte and the byte to push. Every input beat yields exactly
// one output beat telling the byte engine what to do next (load a byte,
// START, STOP, acknowledge control) plus received data and completion status.
// The configuration channel writes slave address, register address, phase
// enables and transfer size; write it only while no transaction is in flight.
// From input beat to output beat the result is registered in the merge stage,
// which updates the sequencer state and reads the transmit buffer RAM, and then
// in the output register, which merges in the RAM read data. One beat per cycle
// is sustained unless the output stalls; the RAM read is the only extra stage.
// Reset clears the sequencer to idle with an empty push pointer; the buffer
// contents are undefined until pushed. When the output is stalled the result
// holds in the output register, one more beat waits in the merge stage and
// then the input stops accepting.
module i2c_master_register_transfer_fsm (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // bus_status[3:0], rx_data[11:4], tx_data[19:12]
  input  logic [2:0]  s_axis_tuser,  // command[2:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // drive_byte[0], byte_out[8:1], request_start[9], request_stop[10],
  // ack_control[12:11], clear_start[13], rx_valid[14], rx_byte[22:15],
  // done_res[23], status[26:24], byte_count[34:27], was_write[35]
  output logic [39:0] m_axis_tdata,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i
);
  import i2cmrt_pkg::*;

  logic [6:0] slave_addr_q;
  logic [7:0] reg_addr_q;
  logic       send_reg_q;
  logic       len_prefix_q;
  logic [7:0] xfer_size_q;

  mode_e      mode_q, mode_d;
  phase_e     phase_q, phase_d;
  logic [7:0] proc_q, proc_d;
  logic [7:0] size_q, size_d;
  logic [7:0] lptr_q, lptr_d;

  logic       a_valid_q, a_valid_d;
  result_t    a_res_q, a_res_d;
  logic       a_ram_q, a_ram_d;
  logic       m_valid_q, m_valid_d;
  result_t    m_res_q, m_res_d;

  logic       s_acc, a_adv;
  logic       fin;
  res_st_e    fin_st;
  logic       ram_we, ram_re;
  logic [7:0] ram_rdata;
  logic [3:0] bus_st;
  logic [7:0] rx_data, tx_data;
  logic [8:0] proc_inc;

  assign bus_st  = s_axis_tdata[3:0];
  assign rx_data = s_axis_tdata[11:4];
  assign tx_data = s_axis_tdata[19:12];

  assign a_adv         = a_valid_q && (!m_valid_q || m_axis_tready);
  assign s_axis_tready = !a_valid_q || a_adv;
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slave_addr_q <= '0;
      reg_addr_q   <= '0;
      send_reg_q   <= 1'b0;
      len_prefix_q <= 1'b0;
      xfer_size_q  <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CfgSlaveAddr: slave_addr_q <= cfg_data_i[6:0];
        CfgRegAddr:   reg_addr_q   <= cfg_data_i;
        CfgSendReg:   send_reg_q   <= cfg_data_i[0];
        CfgLenPrefix: len_prefix_q <= cfg_data_i[0];
        CfgXferSize:  xfer_size_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    mode_d   = mode_q;
    phase_d  = phase_q;
    proc_d   = proc_q;
    size_d   = size_q;
    lptr_d   = lptr_q;
    a_res_d  = '0;
    a_ram_d  = 1'b0;
    fin      = 1'b0;
    fin_st   = StOk;
    ram_we   = 1'b0;
    ram_re   = 1'b0;
    proc_inc = '0;
    if (s_acc) begin
      unique case (cmd_e'(s_axis_tuser))
        CmdWrite, CmdRead: begin
          if (mode_q != ModeIdle) begin
            a_res_d.done_res  = 1'b1;
            a_res_d.status    = StBusy;
            a_res_d.was_write = (cmd_e'(s_axis_tuser) == CmdWrite);
          end else begin
            proc_d = '0;
            if (send_reg_q) begin
              phase_d = PhAddr;
            end else if (len_prefix_q) begin
              phase_d = PhLen;
            end else begin
              phase_d = PhData;
            end
            size_d = xfer_size_q;
            mode_d = (cmd_e'(s_axis_tuser) == CmdWrite) ? ModeTx : ModeRx;
            a_res_d.request_start = 1'b1;
            a_res_d.ack_control   = AckClear;
          end
        end
        CmdEvent: begin
          if (mode_q == ModeTx) begin
            if (bus_st == BsStart) begin
              a_res_d.drive_byte  = 1'b1;
              a_res_d.byte_out    = {slave_addr_q, 1'b0};
              a_res_d.clear_start = 1'b1;
            end else if (bus_st == BsSlawNack) begin
              fin    = 1'b1;
              fin_st = StNak;
            end else if (bus_st == BsDatawNack && (proc_q < size_q || phase_q != PhData)) begin
              fin    = 1'b1;
              fin_st = StNak;
            end else if (bus_st != BsSlawAck && bus_st != BsDatawAck &&
                         bus_st != BsDatawNack) begin
              fin    = 1'b1;
              fin_st = StInvalid;
            end else begin
              unique case (phase_q)
                PhAddr: begin
                  a_res_d.drive_byte = 1'b1;
                  a_res_d.byte_out   = reg_addr_q;
                  phase_d = len_prefix_q ? PhLen : PhData;
                end
                PhLen: begin
                  a_res_d.drive_byte = 1'b1;
                  a_res_d.byte_out   = size_q;
                  phase_d = PhData;
                end
                default: begin
                  if (proc_q < size_q) begin
                    a_res_d.drive_byte = 1'b1;
                    ram_re  = buf_hit(proc_q);
                    a_ram_d = buf_hit(proc_q);
                    proc_d  = proc_q + 8'd1;
                  end else begin
                    fin    = 1'b1;
                    fin_st = StOk;
                  end
                end
              endcase
            end
          end else if (mode_q == ModeRx) begin
            unique case (bus_st_e'(bus_st))
              BsStart: begin
                a_res_d.drive_byte  = 1'b1;
                a_res_d.clear_start = 1'b1;
                if (phase_q == PhAddr) begin
                  a_res_d.byte_out = {slave_addr_q, 1'b0};
                  phase_d = len_prefix_q ? PhLen : PhData;
                end else begin
                  a_res_d.byte_out = {slave_addr_q, 1'b1};
                end
              end
              BsRepStart: begin
                a_res_d.drive_byte  = 1'b1;
                a_res_d.clear_start = 1'b1;
                a_res_d.byte_out    = {slave_addr_q, 1'b1};
              end
              BsSlawNack, BsSlarNack: begin
                fin    = 1'b1;
                fin_st = StNak;
              end
              BsSlawAck: begin
                a_res_d.drive_byte = 1'b1;
                a_res_d.byte_out   = reg_addr_q;
              end
              BsDatawAck, BsDatawNack: begin
                a_res_d.request_start = 1'b1;
              end
              BsSlarAck: begin
                a_res_d.ack_control = (size_q != '0 || len_prefix_q) ? AckSet : AckClear;
              end
              BsDatarAck: begin
                if (phase_q == PhAddr) begin
                  fin    = 1'b1;
                  fin_st = StInvalid;
                end else begin
                  if (phase_q == PhLen) begin
                    if (rx_data < size_q) begin
                      size_d = rx_data;
                    end
                    phase_d = PhData;
                  end else begin
                    a_res_d.rx_valid = 1'b1;
                    a_res_d.rx_byte  = rx_data;
                    if (proc_q != 8'hff) begin
                      proc_d = proc_q + 8'd1;
                    end
                  end
                  proc_inc = {1'b0, proc_d} + 9'd1;
                  a_res_d.ack_control = (proc_inc < {1'b0, size_d}) ? AckSet : AckClear;
                end
              end
              BsDatarNack: begin
                if (proc_q < size_q) begin
                  a_res_d.rx_valid = 1'b1;
                  a_res_d.rx_byte  = rx_data;
                  if (proc_q != 8'hff) begin
                    proc_d = proc_q + 8'd1;
                  end
                end
                fin    = 1'b1;
                fin_st = StOk;
              end
              default: begin
                fin    = 1'b1;
                fin_st = StInvalid;
              end
            endcase
          end
        end
        CmdTimeout: begin
          if (mode_q != ModeIdle) begin
            fin    = 1'b1;
            fin_st = StTimeout;
          end
        end
        CmdPush: begin
          if (mode_q != ModeTx && lptr_q != 8'hff && buf_hit(lptr_q)) begin
            ram_we = 1'b1;
            lptr_d = lptr_q + 8'd1;
          end
        end
        default: ;
      endcase
      if (fin) begin
        a_res_d.request_stop = 1'b1;
        a_res_d.done_res     = 1'b1;
        a_res_d.status       = fin_st;
        a_res_d.byte_count   = proc_d;
        a_res_d.was_write    = (mode_q == ModeTx);
        if (mode_q == ModeTx) begin
          lptr_d = '0;
        end
        mode_d = ModeIdle;
      end
    end
  end

  i2cmrt_ram #(
    .Width (8),
    .Depth (BufferDepth)
  ) u_buf (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (buf_addr(lptr_q)),
    .wdata_i (tx_data),
    .re_i    (ram_re),
    .raddr_i (buf_addr(proc_q)),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    a_valid_d = a_valid_q;
    if (s_acc) begin
      a_valid_d = 1'b1;
    end else if (a_adv) begin
      a_valid_d = 1'b0;
    end
    m_valid_d = m_valid_q;
    m_res_d   = m_res_q;
    if (a_adv) begin
      m_valid_d = 1'b1;
      m_res_d   = a_res_q;
      if (a_ram_q) begin
        m_res_d.byte_out = ram_rdata;
      end
    end else if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= ModeIdle;
      phase_q   <= PhAddr;
      proc_q    <= '0;
      size_q    <= '0;
      lptr_q    <= '0;
      a_valid_q <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      mode_q    <= mode_d;
      phase_q   <= phase_d;
      proc_q    <= proc_d;
      size_q    <= size_d;
      lptr_q    <= lptr_d;
      a_valid_q <= a_valid_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      a_res_q <= a_res_d;
      a_ram_q <= a_ram_d;
    end
    m_res_q <= m_res_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {4'd0, m_res_q};

`ifndef ASSERT_OFF
  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (a_valid_q && !a_adv) |-> !s_axis_tready)
    else $error("input accepted while merge stage is stalled");

  a_finish_goes_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_acc && fin) |=> (mode_q == ModeIdle && lptr_q == $past(lptr_d)))
    else $error("sequencer not idle after completion");

  a_no_push_in_tx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == ModeTx) |-> !ram_we)
    else $error("buffer written during a write transfer");

  a_tx_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == ModeTx) |-> (proc_q <= size_q))
    else $error("write count passed transfer size");

  a_ram_read_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (a_valid_q && a_ram_q) |-> !ram_re || a_adv)
    else $error("buffer read issued over a pending read");
`endif

endmodule

// ===== bench/i2cmrt_checker.sv =====
// Result predictor and scoreboard for the I2C register transfer sequencer.
module i2cmrt_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,
  input  logic [2:0]  s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [39:0] m_axis_tdata,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i,
  output int          fail_cnt_o,
  output int          pending_o
);
  import i2cmrt_pkg::*;

  logic [6:0] slave_q;
  logic [7:0] reg_addr_q;
  logic       send_reg_q;
  logic       len_pre_q;
  logic [7:0] size_q;

  mode_e      mode_q;
  phase_e     phase_q;
  logic [7:0] moved_q;
  logic [7:0] limit_q;
  logic [7:0] load_ptr_q;
  logic [7:0] tx_buf [BufferDepth];

  result_t    beat_q [$];
  int         fails;
  int         out_idx;

  function automatic result_t closed(result_t r, res_st_e code);
    r.request_stop = 1'b1;
    r.done_res     = 1'b1;
    r.status       = code;
    r.byte_count   = moved_q;
    r.was_write    = (mode_q == ModeTx);
    if (mode_q == ModeTx) load_ptr_q = 8'd0;
    mode_q = ModeIdle;
    return r;
  endfunction

  function automatic result_t tx_reply(result_t r, logic [3:0] st);
    if (st == BsStart) begin
      r.drive_byte  = 1'b1;
      r.byte_out    = {slave_q, 1'b0};
      r.clear_start = 1'b1;
    end else if (st == BsSlawNack) begin
      r = closed(r, StNak);
    end else if (st == BsDatawNack && (moved_q < limit_q || phase_q != PhData)) begin
      r = closed(r, StNak);
    end else if (st != BsSlawAck && st != BsDatawAck && st != BsDatawNack) begin
      r = closed(r, StInvalid);
    end else if (phase_q == PhAddr) begin
      r.drive_byte = 1'b1;
      r.byte_out   = reg_addr_q;
      phase_q      = len_pre_q ? PhLen : PhData;
    end else if (phase_q == PhLen) begin
      r.drive_byte = 1'b1;
      r.byte_out   = limit_q;
      phase_q      = PhData;
    end else if (moved_q < limit_q) begin
      r.drive_byte = 1'b1;
      r.byte_out   = (int'(moved_q) < BufferDepth) ? tx_buf[moved_q] : 8'h00;
      moved_q++;
    end else begin
      r = closed(r, StOk);
    end
    return r;
  endfunction

  function automatic result_t rx_take(result_t r, logic [7:0] rx);
    r.rx_valid = 1'b1;
    r.rx_byte  = rx;
    if (moved_q < 8'd255) moved_q++;
    return r;
  endfunction

  function automatic result_t rx_reply(result_t r, logic [3:0] st, logic [7:0] rx);
    case (st)
      BsStart: begin
        r.clear_start = 1'b1;
        r.drive_byte  = 1'b1;
        if (phase_q == PhAddr) begin
          r.byte_out = {slave_q, 1'b0};
          phase_q    = len_pre_q ? PhLen : PhData;
        end else begin
          r.byte_out = {slave_q, 1'b1};
        end
      end
      BsRepStart: begin
        r.clear_start = 1'b1;
        r.drive_byte  = 1'b1;
        r.byte_out    = {slave_q, 1'b1};
      end
      BsSlawNack, BsSlarNack: r = closed(r, StNak);
      BsSlawAck: begin
        r.drive_byte = 1'b1;
        r.byte_out   = reg_addr_q;
      end
      BsDatawAck, BsDatawNack: r.request_start = 1'b1;
      BsSlarAck: r.ack_control = (limit_q != 8'd0 || len_pre_q) ? AckSet : AckClear;
      BsDatarAck: begin
        if (phase_q == PhAddr) begin
          r = closed(r, StInvalid);
        end else begin
          if (phase_q == PhLen) begin
            if (rx < limit_q) limit_q = rx;
            phase_q = PhData;
          end else begin
            r = rx_take(r, rx);
          end
          r.ack_control = ({1'b0, moved_q} + 9'd1 < {1'b0, limit_q}) ? AckSet : AckClear;
        end
      end
      BsDatarNack: begin
        if (moved_q < limit_q) r = rx_take(r, rx);
        r = closed(r, StOk);
      end
      default: r = closed(r, StInvalid);
    endcase
    return r;
  endfunction

  function automatic result_t predict_beat(logic [2:0] cmd, logic [3:0] st,
                                           logic [7:0] rx, logic [7:0] tx);
    result_t r;
    r = '0;
    case (cmd)
      CmdWrite, CmdRead: begin
        if (mode_q != ModeIdle) begin
          r.done_res  = 1'b1;
          r.status    = StBusy;
          r.was_write = (cmd == CmdWrite);
        end else begin
          moved_q         = 8'd0;
          phase_q         = send_reg_q ? PhAddr : (len_pre_q ? PhLen : PhData);
          limit_q         = size_q;
          mode_q          = (cmd == CmdWrite) ? ModeTx : ModeRx;
          r.request_start = 1'b1;
          r.ack_control   = AckClear;
        end
      end
      CmdEvent: begin
        if (mode_q == ModeTx) r = tx_reply(r, st);
        else if (mode_q == ModeRx) r = rx_reply(r, st, rx);
      end
      CmdTimeout: begin
        if (mode_q != ModeIdle) r = closed(r, StTimeout);
      end
      CmdPush: begin
        if (mode_q != ModeTx && load_ptr_q < 8'd255 && int'(load_ptr_q) < BufferDepth) begin
          tx_buf[load_ptr_q] = tx;
          load_ptr_q++;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic cmp_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      if (fails < 10)
        $display("result beat %0d: %s expected %0h, got %0h", out_idx, name, want, got);
      fails++;
    end
  endtask

  task automatic check_beat(result_t got);
    result_t want;
    if (beat_q.size() == 0) begin
      if (fails < 10) $display("result beat %0d arrived with nothing expected: %h",
                               out_idx, got);
      fails++;
    end else begin
      want = beat_q.pop_front();
      cmp_field("drive_byte", 8'(want.drive_byte), 8'(got.drive_byte));
      cmp_field("byte_out", want.byte_out, got.byte_out);
      cmp_field("request_start", 8'(want.request_start), 8'(got.request_start));
      cmp_field("request_stop", 8'(want.request_stop), 8'(got.request_stop));
      cmp_field("ack_control", 8'(want.ack_control), 8'(got.ack_control));
      cmp_field("clear_start", 8'(want.clear_start), 8'(got.clear_start));
      cmp_field("rx_valid", 8'(want.rx_valid), 8'(got.rx_valid));
      cmp_field("rx_byte", want.rx_byte, got.rx_byte);
      cmp_field("done_res", 8'(want.done_res), 8'(got.done_res));
      cmp_field("status", 8'(want.status), 8'(got.status));
      cmp_field("byte_count", want.byte_count, got.byte_count);
      cmp_field("was_write", 8'(want.was_write), 8'(got.was_write));
    end
    out_idx++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slave_q    = '0;
      reg_addr_q = '0;
      send_reg_q = 1'b0;
      len_pre_q  = 1'b0;
      size_q     = '0;
      mode_q     = ModeIdle;
      phase_q    = PhAddr;
      moved_q    = '0;
      limit_q    = '0;
      load_ptr_q = '0;
      beat_q.delete();
      fails      = 0;
      out_idx    = 0;
      fail_cnt_o <= 0;
      pending_o  <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) check_beat(result_t'(m_axis_tdata[35:0]));
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CfgSlaveAddr: slave_q    = cfg_data_i[6:0];
          CfgRegAddr:   reg_addr_q = cfg_data_i;
          CfgSendReg:   send_reg_q = cfg_data_i[0];
          CfgLenPrefix: len_pre_q  = cfg_data_i[0];
          CfgXferSize:  size_q     = cfg_data_i;
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready)
        beat_q.push_back(predict_beat(s_axis_tuser, s_axis_tdata[3:0],
                                      s_axis_tdata[11:4], s_axis_tdata[19:12]));
      fail_cnt_o <= fails;
      pending_o  <= beat_q.size();
    end
  end

endmodule

// ===== bench/tb_i2c_master_register_transfer_fsm.sv =====
// Top of the I2C register transfer sequencer testbench: stimulus, idling and verdict.
module tb_i2c_master_register_transfer_fsm;
  import i2cmrt_pkg::*;

  localparam int           StallLimit   = 2000;
  localparam int           RandomBeats  = 750;
  localparam logic [2:0]   CmdUnusedLo  = 3'd5;
  localparam logic [2:0]   CmdUnusedHi  = 3'd7;
  localparam logic [3:0]   BsBeyond     = 4'hF;

  logic        clk_i;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata  = '0;  // bus_status[3:0], rx_data[11:4], tx_data[19:12]
  logic [2:0]  s_axis_tuser  = '0;  // command[2:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // drive_byte[0], byte_out[8:1], request_start[9], request_stop[10],
  // ack_control[12:11], clear_start[13], rx_valid[14], rx_byte[22:15],
  // done_res[23], status[26:24], byte_count[34:27], was_write[35]
  logic [39:0] m_axis_tdata;
  logic        cfg_valid_i   = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i   = '0;
  logic [7:0]  cfg_data_i    = '0;

  int          fail_cnt;
  int          pending;
  int          src_idle  = 0;
  int          snk_stall = 0;
  int          stall_cnt = 0;
  int          beats     = 0;
  bit          timed_out = 1'b0;

  logic        cur_send_reg = 1'b0;
  logic        cur_len_pre  = 1'b0;
  logic [7:0]  cur_size     = '0;

  i2c_master_register_transfer_fsm u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  i2cmrt_checker u_chk (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .fail_cnt_o    (fail_cnt),
    .pending_o     (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= snk_stall);
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      stall_cnt <= 0;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

  task automatic send(logic [2:0] cmd, logic [3:0] st, logic [7:0] rx, logic [7:0] tx);
    if ($urandom_range(99) < src_idle) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < src_idle);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {4'd0, tx, rx, st};
    do @(posedge clk_i); while (!s_axis_tready);
    beats++;
  endtask

  task automatic bus_ev(logic [3:0] st, logic [7:0] rx);
    if ($urandom_range(99) < 3) begin
      send(3'($urandom_range(7)), 4'($urandom), 8'($urandom), 8'($urandom));
    end else begin
      send(CmdEvent, st, rx, 8'($urandom));
    end
  endtask

  // close any open transfer, then hold until every result beat is back
  task automatic drain();
    send(CmdTimeout, 4'($urandom), 8'($urandom), 8'($urandom));
    s_axis_tvalid <= 1'b0;
    repeat (2) @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic configure(logic [7:0] slave, logic [7:0] regad, logic send_reg,
                           logic len_pre, logic [7:0] size);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= CfgSlaveAddr;
    cfg_data_i  <= slave;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_index_i <= CfgRegAddr;
    cfg_data_i  <= regad;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_index_i <= CfgSendReg;
    cfg_data_i  <= {7'($urandom), send_reg};
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_index_i <= CfgLenPrefix;
    cfg_data_i  <= {7'($urandom), len_pre};
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_index_i <= CfgXferSize;
    cfg_data_i  <= size;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i  <= 1'b0;
    cur_send_reg = send_reg;
    cur_len_pre  = len_pre;
    cur_size     = size;
  endtask

  task automatic configure_random();
    logic [7:0] sz;
    case ($urandom_range(15))
      0:       sz = 8'd255;
      1:       sz = 8'd0;
      default: sz = 8'($urandom_range(6));
    endcase
    configure(8'($urandom), 8'($urandom), 1'($urandom), 1'($urandom), sz);
  endtask

  // end a transfer part-way (timeout, NAK or unexpected status) or send a start command while it is busy
  task automatic cut_short(logic is_write);
    case ($urandom_range(3))
      0: send(CmdTimeout, 4'($urandom), 8'($urandom), 8'($urandom));
      1: send(CmdEvent, is_write ? BsDatawNack : BsSlarNack, 8'($urandom), 8'($urandom));
      2: send(CmdEvent, BsOther, 8'($urandom), 8'($urandom));
      default: send(3'($urandom_range(1)), 4'($urandom), 8'($urandom), 8'($urandom));
    endcase
  endtask

  task automatic write_xfer();
    int n_ack;
    int cut;
    repeat ($urandom_range(3)) send(CmdPush, 4'($urandom), 8'($urandom), 8'($urandom));
    send(CmdWrite, 4'($urandom), 8'($urandom), 8'($urandom));
    bus_ev(BsStart, 8'($urandom));
    bus_ev(BsSlawAck, 8'($urandom));
    n_ack = int'(cur_send_reg) + int'(cur_len_pre) + int'(cur_size);
    cut   = ($urandom_range(9) == 0) ? $urandom_range(n_ack) : -1;
    for (int i = 0; i < n_ack; i++) begin
      if (i == cut) begin
        cut_short(1'b1);
        return;
      end
      bus_ev(BsDatawAck, 8'($urandom));
    end
    bus_ev($urandom_range(1) ? BsDatawAck : BsDatawNack, 8'($urandom));
  endtask

  task automatic read_xfer();
    int n;
    int cut;
    logic [7:0] len;
    send(CmdRead, 4'($urandom), 8'($urandom), 8'($urandom));
    if (cur_send_reg) begin
      bus_ev(BsStart, 8'($urandom));
      bus_ev(BsSlawAck, 8'($urandom));
      bus_ev($urandom_range(1) ? BsDatawAck : BsDatawNack, 8'($urandom));
      bus_ev($urandom_range(1) ? BsRepStart : BsStart, 8'($urandom));
    end else begin
      bus_ev(BsStart, 8'($urandom));
    end
    bus_ev(BsSlarAck, 8'($urandom));
    n = int'(cur_size);
    if (cur_len_pre) begin
      len = $urandom_range(1) ? 8'($urandom_range(int'(cur_size))) : 8'($urandom);
      bus_ev(BsDatarAck, len);
      if (int'(len) < n) n = int'(len);
    end
    cut = ($urandom_range(9) == 0) ? $urandom_range(n) : -1;
    for (int i = 0; i < n - 1; i++) begin
      if (i == cut) begin
        cut_short(1'b0);
        return;
      end
      bus_ev(BsDatarAck, 8'($urandom));
    end
    if ($urandom_range(7) == 0) bus_ev(BsDatarAck, 8'($urandom));
    bus_ev(BsDatarNack, 8'($urandom));
  endtask

  task automatic directed();
    send(CmdEvent, BsStart, 8'h00, 8'h00);
    send(CmdTimeout, BsStart, 8'h00, 8'h00);
    send(CmdUnusedLo, BsOther, 8'hFF, 8'hFF);
    send(CmdUnusedHi, BsBeyond, 8'hFF, 8'hFF);
    // full write with register and length phases, busy starts in the middle
    send(CmdWrite, BsStart, 8'h00, 8'h00);
    send(CmdEvent, BsStart, 8'h00, 8'h00);
    send(CmdEvent, BsSlawAck, 8'h00, 8'h00);
    send(CmdEvent, BsDatawAck, 8'h00, 8'h00);
    send(CmdEvent, BsDatawAck, 8'h00, 8'h00);
    send(CmdRead, BsStart, 8'h00, 8'h00);
    send(CmdWrite, BsStart, 8'h00, 8'h00);
    send(CmdPush, BsStart, 8'h00, 8'hA5);
    send(CmdEvent, BsDatawAck, 8'h00, 8'h00);
    send(CmdEvent, BsDatawNack, 8'h00, 8'h00);
    // read with length byte that shrinks the size, then an overrun byte
    send(CmdRead, BsStart, 8'h00, 8'h00);
    send(CmdEvent, BsStart, 8'h00, 8'h00);
    send(CmdEvent, BsSlawAck, 8'h00, 8'h00);
    send(CmdEvent, BsDatawAck, 8'h00, 8'h00);
    send(CmdEvent, BsRepStart, 8'h00, 8'h00);
    send(CmdEvent, BsSlarAck, 8'h00, 8'h00);
    send(CmdEvent, BsDatarAck, 8'h01, 8'h00);
    send(CmdEvent, BsDatarAck, 8'hFF, 8'h00);
    send(CmdEvent, BsDatarAck, 8'h00, 8'h00);
    send(CmdEvent, BsDatarNack, 8'h5A, 8'h00);
    // early NAK, unexpected status and timeout
    send(CmdWrite, BsStart, 8'h00, 8'h00);
    send(CmdEvent, BsDatawNack, 8'h00, 8'h00);
    send(CmdRead, BsStart, 8'h00, 8'h00);
    send(CmdEvent, BsBeyond, 8'h00, 8'h00);
    send(CmdWrite, BsStart, 8'h00, 8'h00);
    send(CmdTimeout, BsStart, 8'h00, 8'h00);
  endtask

  task automatic run_all();
    int goal;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // load every reachable buffer entry, plus one push past the end
    repeat (256) send(CmdPush, 4'($urandom), 8'($urandom), 8'($urandom));
    configure(8'hFF, 8'hFF, 1'b1, 1'b1, 8'd2);
    directed();
    configure(8'h00, 8'h00, 1'b0, 1'b0, 8'd0);
    write_xfer();
    read_xfer();
    configure(8'h7F, 8'hFF, 1'b1, 1'b1, 8'd255);
    write_xfer();
    read_xfer();
    goal = beats + RandomBeats;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       begin src_idle = 0;  snk_stall = 0;  end
        1:       begin src_idle = 49; snk_stall = 0;  end
        2:       begin src_idle = 0;  snk_stall = 49; end
        default: begin src_idle = 37; snk_stall = 37; end
      endcase
      while (beats < goal - (3 - ph) * RandomBeats / 4) begin
        if ($urandom_range(5) == 0) configure_random();
        case ($urandom_range(9))
          0:       send(3'($urandom), 4'($urandom), 8'($urandom), 8'($urandom));
          1, 2, 3, 4: write_xfer();
          default: read_xfer();
        endcase
      end
    end
    s_axis_tvalid <= 1'b0;
    repeat (2) @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic watchdog();
    while (stall_cnt < StallLimit) @(posedge clk_i);
    timed_out = 1'b1;
  endtask

  initial begin
    fork
      run_all();
      watchdog();
    join_any
    if (!timed_out && fail_cnt == 0 && pending == 0) begin
      $display("tb_i2c_master_register_transfer_fsm OK");
    end else begin
      $display("tb_i2c_master_register_transfer_fsm NOT OK");
    end
    $finish;
  end

endmodule
